### rtl/ring_queue_index_manager_defines.svh
// Assertion macros for the ring queue index manager checker.
// Depends on nothing; included by the checker file only.
`ifndef RING_QUEUE_INDEX_MANAGER_DEFINES_SVH
`define RING_QUEUE_INDEX_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQIM_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("rqim check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RQIM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("rqim check failed");

`endif

### rtl/rqim_pkg.sv
// Shared widths, action codes, structs and helpers of the ring queue index manager.
// Depends on nothing; used by the interfaces, the step logic, the top level and the checker.
package rqim_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int POS_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = POS_W + 1;
    localparam int SUM_W     = CNT_W + 1;
    localparam int ACTION_W  = 3;

    localparam logic [CNT_W-1:0] MAX_SLOTS_C = CNT_W'(MAX_SLOTS);

    localparam logic [ACTION_W-1:0] ACT_RESERVE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMIT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CONSUME   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PEEK_SPAN = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK_IDX  = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CNT_W-1:0]    count;
        logic [POS_W-1:0]    element_index;
    } rqim_item_t;

    typedef struct packed {
        logic             accepted;
        logic [POS_W-1:0] offset_a;
        logic [CNT_W-1:0] length_a;
        logic [POS_W-1:0] offset_b;
        logic [CNT_W-1:0] length_b;
        logic [CNT_W-1:0] amount;
        logic [POS_W-1:0] clamped_index;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] free_count;
        logic             error;
    } rqim_result_t;

    typedef struct packed {
        logic [CNT_W-1:0] capacity;
        logic [POS_W-1:0] write_pos;
        logic [POS_W-1:0] read_pos;
        logic [CNT_W-1:0] fill;
    } rqim_state_t;

    function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] result;
        if (value == '0)
        begin
            result = CNT_W'(1);
        end
        else if (value > MAX_SLOTS_C)
        begin
            result = MAX_SLOTS_C;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

### rtl/rqim_if.sv
// Valid/ready channel interfaces for requests, results and the capacity write.
// Depends on rqim_pkg for widths.
interface rqim_req_if;
    import rqim_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CNT_W-1:0]    count;
    logic [POS_W-1:0]    element_index;

    modport source (output valid, output action, output count, output element_index,
                    input ready);
    modport sink (input valid, input action, input count, input element_index,
                  output ready);
endinterface

interface rqim_rsp_if;
    import rqim_pkg::*;

    logic             valid;
    logic             ready;
    logic             accepted;
    logic [POS_W-1:0] offset_a;
    logic [CNT_W-1:0] length_a;
    logic [POS_W-1:0] offset_b;
    logic [CNT_W-1:0] length_b;
    logic [CNT_W-1:0] amount;
    logic [POS_W-1:0] clamped_index;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_count;
    logic             error;

    modport source (output valid, output accepted, output offset_a, output length_a,
                    output offset_b, output length_b, output amount, output clamped_index,
                    output fill_count, output free_count, output error, input ready);
    modport sink (input valid, input accepted, input offset_a, input length_a,
                  input offset_b, input length_b, input amount, input clamped_index,
                  input fill_count, input free_count, input error, output ready);
endinterface

interface rqim_cfg_if;
    import rqim_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

### rtl/ring_queue_index_manager.sv
//  channel | modport      | transfer moves
//  cfg     | rqim_cfg_if  | new capacity, resets the queue pointers
//  req     | rqim_req_if  | one action with count and element index
//  rsp     | rqim_rsp_if  | one result for each request
// A request is registered on transfer and evaluated from that register into the result
// register when that is free or being read; one request per cycle while results are taken.
// The pointer state is updated in the cycle a request moves into the result register.
// Reset sets capacity to 1024 and all pointers and the fill count to zero.
// A stalled result holds the request register, which then stalls the request side.
// Ring queue index manager top level; depends on rqim_pkg, the interfaces and rqim_step.
module ring_queue_index_manager (
    input logic         clk,
    input logic         rst_n,
    rqim_cfg_if.sink    cfg,
    rqim_req_if.sink    req,
    rqim_rsp_if.source  rsp
);
    import rqim_pkg::*;

    rqim_item_t   item_reg;
    logic         item_valid_reg;
    rqim_result_t result_reg;
    rqim_result_t result_next;
    logic         result_valid_reg;
    rqim_state_t  state_reg;
    rqim_state_t  state_next;
    logic         advance;
    logic         req_take;

    assign advance   = item_valid_reg && (!result_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;
    assign req_take  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    rqim_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '{capacity: MAX_SLOTS_C, write_pos: '0, read_pos: '0,
                                  fill: '0};
        end
        else
        begin
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                state_reg <= '{capacity: clamp_capacity(cfg.capacity), write_pos: '0,
                               read_pos: '0, fill: '0};
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= '{action: req.action, count: req.count,
                          element_index: req.element_index};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid         = result_valid_reg;
    assign rsp.accepted      = result_reg.accepted;
    assign rsp.offset_a      = result_reg.offset_a;
    assign rsp.length_a      = result_reg.length_a;
    assign rsp.offset_b      = result_reg.offset_b;
    assign rsp.length_b      = result_reg.length_b;
    assign rsp.amount        = result_reg.amount;
    assign rsp.clamped_index = result_reg.clamped_index;
    assign rsp.fill_count    = result_reg.fill_count;
    assign rsp.free_count    = result_reg.free_count;
    assign rsp.error         = result_reg.error;

endmodule

### rtl/rqim_step.sv
// Combinational evaluation of one queue action against the current pointer state.
// Depends on rqim_pkg for types and action codes.
module rqim_step (
    input  rqim_pkg::rqim_state_t  state,
    input  rqim_pkg::rqim_item_t   item,
    output rqim_pkg::rqim_result_t result,
    output rqim_pkg::rqim_state_t  state_next
);
    import rqim_pkg::*;

    logic [SUM_W-1:0] cap_ext;
    logic [SUM_W-1:0] wp_sum;
    logic [SUM_W-1:0] fill_sum;
    logic [CNT_W-1:0] clamped;
    logic [SUM_W-1:0] rp_sum;
    logic             rp_wraps;
    logic [SUM_W-1:0] rp_wrapped;
    logic             idx_past_end;
    logic [CNT_W-1:0] fill_less;
    logic [POS_W-1:0] use_index;
    logic [SUM_W-1:0] idx_sum;
    logic [SUM_W-1:0] idx_wrapped;

    always_comb
    begin
        cap_ext      = {1'b0, state.capacity};
        wp_sum       = {2'b00, state.write_pos} + {1'b0, item.count};
        fill_sum     = {1'b0, state.fill} + {1'b0, item.count};
        clamped      = (item.count < state.fill) ? item.count : state.fill;
        rp_sum       = {2'b00, state.read_pos} + {1'b0, clamped};
        rp_wraps     = rp_sum >= cap_ext;
        rp_wrapped   = rp_wraps ? (rp_sum - cap_ext) : rp_sum;
        fill_less    = state.fill - CNT_W'(1);
        idx_past_end = {1'b0, item.element_index} >= state.fill;
        use_index    = idx_past_end ? fill_less[POS_W-1:0] : item.element_index;
        idx_sum      = {2'b00, state.read_pos} + {2'b00, use_index};
        idx_wrapped  = (idx_sum >= cap_ext) ? (idx_sum - cap_ext) : idx_sum;

        state_next = state;
        result     = '0;

        case (item.action)
            ACT_RESERVE:
            begin
                if (state.fill != state.capacity)
                begin
                    result.accepted = 1'b1;
                    result.offset_a = state.write_pos;
                end
            end
            ACT_COMMIT:
            begin
                if ((wp_sum > cap_ext) || (fill_sum > cap_ext))
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    state_next.write_pos = (wp_sum == cap_ext) ? '0 : wp_sum[POS_W-1:0];
                    state_next.fill      = fill_sum[CNT_W-1:0];
                end
            end
            ACT_CONSUME:
            begin
                state_next.read_pos = rp_wrapped[POS_W-1:0];
                state_next.fill     = state.fill - clamped;
                result.amount       = clamped;
                result.offset_a     = rp_wrapped[POS_W-1:0];
            end
            ACT_PEEK_SPAN:
            begin
                result.offset_a = state.read_pos;
                result.amount   = state.fill;
                if (rp_wraps)
                begin
                    result.length_a = state.capacity - {1'b0, state.read_pos};
                    result.length_b = rp_wrapped[CNT_W-1:0];
                end
                else
                begin
                    result.length_a = clamped;
                end
            end
            ACT_PEEK_IDX:
            begin
                if (state.fill != '0)
                begin
                    result.accepted      = 1'b1;
                    result.offset_a      = idx_wrapped[POS_W-1:0];
                    result.amount        = idx_past_end ? fill_less : state.fill;
                    result.clamped_index = use_index;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase

        result.fill_count = state_next.fill;
        result.free_count = state_next.capacity - state_next.fill;
    end

endmodule

### rtl/rqim_checker.sv
// Port-level checks of the ring queue index manager and the bind that attaches them.
// Depends on rqim_pkg and ring_queue_index_manager_defines.svh.
`include "ring_queue_index_manager_defines.svh"

module rqim_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    rsp_accepted,
    input logic [rqim_pkg::CNT_W-1:0] rsp_length_a,
    input logic [rqim_pkg::CNT_W-1:0] rsp_length_b,
    input logic [rqim_pkg::CNT_W-1:0] rsp_amount,
    input logic [rqim_pkg::CNT_W-1:0] rsp_fill_count,
    input logic [rqim_pkg::CNT_W-1:0] rsp_free_count,
    input logic                    rsp_error
);
    import rqim_pkg::*;

    logic [CNT_W:0] occupancy_sum;

    assign occupancy_sum = {1'b0, rsp_fill_count} + {1'b0, rsp_free_count};

    // A result waiting for its transfer must stay offered.
    `RQIM_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // Fill plus free is the capacity, which lies between one and the ring size.
    `RQIM_ASSERT_NOW(a_occupancy, clk, rst_n, rsp_valid, (occupancy_sum != '0) && (occupancy_sum <= {1'b0, MAX_SLOTS_C}))

    // A refused commit reports nothing else.
    `RQIM_ASSERT_NOW(a_error_alone, clk, rst_n, rsp_valid && rsp_error, !rsp_accepted && (rsp_amount == '0) && (rsp_length_a == '0))

    // A wrapped second span always follows a non-empty first span.
    `RQIM_ASSERT_NOW(a_span_order, clk, rst_n, rsp_valid && (rsp_length_b != '0), (rsp_length_a != '0) && !rsp_error && !rsp_accepted)

endmodule

bind ring_queue_index_manager rqim_checker u_rqim_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_accepted   (rsp.accepted),
    .rsp_length_a   (rsp.length_a),
    .rsp_length_b   (rsp.length_b),
    .rsp_amount     (rsp.amount),
    .rsp_fill_count (rsp.fill_count),
    .rsp_free_count (rsp.free_count),
    .rsp_error      (rsp.error)
);

### tb/rqim_ring_checker.sv
// Scoreboard for the ring queue index manager: watches the capacity, request and result
// channels, predicts each result from its own copy of the ring pointers and compares.
// Depends on rqim_pkg and the channel interfaces in rqim_if.sv.
module rqim_ring_checker
    import rqim_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rqim_cfg_if  cfg,
    rqim_req_if  req,
    rqim_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CNT_W-1:0] ring_capacity;
    logic [CNT_W-1:0] ring_fill;
    logic [POS_W-1:0] ring_head;
    logic [POS_W-1:0] ring_tail;
    rqim_result_t     ring_due[$];

    function automatic rqim_result_t ring_outcome(input rqim_item_t item);
        rqim_result_t r;
        int           n;
        int           w;
        int           pos;
        int           cap;
        r   = '0;
        cap = int'(ring_capacity);
        n   = (int'(item.count) < int'(ring_fill)) ? int'(item.count) : int'(ring_fill);
        case (item.action)
            ACT_RESERVE:
            begin
                if (ring_fill != ring_capacity)
                begin
                    r.accepted = 1'b1;
                    r.offset_a = ring_head;
                end
            end
            ACT_COMMIT:
            begin
                if (int'(ring_head) + int'(item.count) > cap
                    || int'(ring_fill) + int'(item.count) > cap)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    pos       = int'(ring_head) + int'(item.count);
                    ring_head = (pos == cap) ? '0 : POS_W'(pos);
                    ring_fill = ring_fill + item.count;
                end
            end
            ACT_CONSUME:
            begin
                pos = int'(ring_tail) + n;
                if (pos >= cap)
                begin
                    pos = pos - cap;
                end
                ring_tail  = POS_W'(pos);
                ring_fill  = ring_fill - CNT_W'(n);
                r.amount   = CNT_W'(n);
                r.offset_a = ring_tail;
            end
            ACT_PEEK_SPAN:
            begin
                pos        = n + int'(ring_tail);
                r.offset_a = ring_tail;
                if (pos >= cap)
                begin
                    r.length_a = CNT_W'(cap - int'(ring_tail));
                    r.length_b = CNT_W'(pos - cap);
                end
                else
                begin
                    r.length_a = CNT_W'(n);
                end
                r.amount = ring_fill;
            end
            ACT_PEEK_IDX:
            begin
                if (ring_fill != '0)
                begin
                    n = int'(ring_fill);
                    w = int'(item.element_index);
                    if (w >= n)
                    begin
                        n = n - 1;
                        w = n;
                    end
                    pos             = w + int'(ring_tail);
                    r.offset_a      = POS_W'((pos >= cap) ? pos - cap : pos);
                    r.accepted      = 1'b1;
                    r.amount        = CNT_W'(n);
                    r.clamped_index = POS_W'(w);
                end
            end
            default:
            begin
            end
        endcase
        r.fill_count = ring_fill;
        r.free_count = ring_capacity - ring_fill;
        return r;
    endfunction

    function automatic string result_diffs(input rqim_result_t e, input rqim_result_t a);
        string s = "";
        if (e.accepted !== a.accepted)
            s = {s, $sformatf(" accepted exp %0d got %0d", e.accepted, a.accepted)};
        if (e.offset_a !== a.offset_a)
            s = {s, $sformatf(" offset_a exp %0d got %0d", e.offset_a, a.offset_a)};
        if (e.length_a !== a.length_a)
            s = {s, $sformatf(" length_a exp %0d got %0d", e.length_a, a.length_a)};
        if (e.offset_b !== a.offset_b)
            s = {s, $sformatf(" offset_b exp %0d got %0d", e.offset_b, a.offset_b)};
        if (e.length_b !== a.length_b)
            s = {s, $sformatf(" length_b exp %0d got %0d", e.length_b, a.length_b)};
        if (e.amount !== a.amount)
            s = {s, $sformatf(" amount exp %0d got %0d", e.amount, a.amount)};
        if (e.clamped_index !== a.clamped_index)
            s = {s, $sformatf(" clamped_index exp %0d got %0d", e.clamped_index,
                              a.clamped_index)};
        if (e.fill_count !== a.fill_count)
            s = {s, $sformatf(" fill_count exp %0d got %0d", e.fill_count, a.fill_count)};
        if (e.free_count !== a.free_count)
            s = {s, $sformatf(" free_count exp %0d got %0d", e.free_count, a.free_count)};
        if (e.error !== a.error)
            s = {s, $sformatf(" error exp %0d got %0d", e.error, a.error)};
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rqim_item_t   item;
        rqim_result_t seen;
        rqim_result_t due;
        string        diffs;
        if (!rst_n)
        begin
            ring_capacity = CNT_W'(MAX_SLOTS);
            ring_fill     = '0;
            ring_head     = '0;
            ring_tail     = '0;
            ring_due.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.capacity == '0)
                    ring_capacity = CNT_W'(1);
                else if (cfg.capacity > CNT_W'(MAX_SLOTS))
                    ring_capacity = CNT_W'(MAX_SLOTS);
                else
                    ring_capacity = cfg.capacity;
                ring_fill = '0;
                ring_head = '0;
                ring_tail = '0;
            end
            if (rsp.valid && rsp.ready)
            begin
                seen.accepted      = rsp.accepted;
                seen.offset_a      = rsp.offset_a;
                seen.length_a      = rsp.length_a;
                seen.offset_b      = rsp.offset_b;
                seen.length_b      = rsp.length_b;
                seen.amount        = rsp.amount;
                seen.clamped_index = rsp.clamped_index;
                seen.fill_count    = rsp.fill_count;
                seen.free_count    = rsp.free_count;
                seen.error         = rsp.error;
                if (ring_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with no request pending: %p",
                                 $realtime, seen);
                end
                else
                begin
                    due   = ring_due.pop_front();
                    diffs = result_diffs(due, seen);
                    if (diffs != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch:%s", $realtime, diffs);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                item.action        = req.action;
                item.count         = req.count;
                item.element_index = req.element_index;
                ring_due.push_back(ring_outcome(item));
            end
            outstanding = ring_due.size();
        end
    end

endmodule

### tb/tb.sv
// Top of the ring queue index manager testbench: clock, reset, capacity writes and
// request stimulus with random idling on both channels, plus the final verdict.
// Depends on rqim_pkg, rqim_if.sv, the block itself and rqim_ring_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rqim_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 3'd7;
    localparam int PHASES = 12;
    localparam int PHASE_CAPACITY [PHASES] = '{1, 0, 2, 2047, 3, 1025, 17, 64, 1024, 300,
                                                1, 1024};
    localparam int PHASE_ITEMS = 128;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   ring_span;
    bit   steady_feed;

    rqim_cfg_if cfg_ch ();
    rqim_req_if req_ch ();
    rqim_rsp_if rsp_ch ();

    ring_queue_index_manager uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rqim_ring_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input int cnt,
                                input int idx);
        int gap;
        bit took;
        gap = steady_feed ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.count         <= CNT_W'(cnt);
        req_ch.element_index <= POS_W'(idx);
        do
        begin
            @(negedge clk);
            took = req_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_capacity(input int value);
        bit took;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= CNT_W'(value);
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_ch.valid <= 1'b0;
        ring_span = (value == 0) ? 1 : ((value > MAX_SLOTS) ? MAX_SLOTS : value);
    endtask

    task automatic random_burst(input int n);
        int          r;
        logic [ACTION_W-1:0] act;
        int unsigned cnt;
        int unsigned idx;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 34)
                act = ACT_COMMIT;
            else if (r < 58)
                act = ACT_CONSUME;
            else if (r < 68)
                act = ACT_RESERVE;
            else if (r < 80)
                act = ACT_PEEK_SPAN;
            else if (r < 93)
                act = ACT_PEEK_IDX;
            else
                act = ACTION_W'($urandom_range(int'(ACT_PEEK_IDX) + 1, (1 << ACTION_W) - 1));
            r = $urandom_range(0, 99);
            if (r < 60)
                cnt = $urandom_range(0, ring_span / 4 + 1);
            else if (r < 90)
                cnt = $urandom_range(0, ring_span);
            else
                cnt = $urandom_range(0, (1 << CNT_W) - 1);
            if ($urandom_range(0, 9) < 6)
                idx = $urandom_range(0, ring_span - 1);
            else
                idx = $urandom_range(0, (1 << POS_W) - 1);
            send_request(act, int'(cnt), int'(idx));
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int on_len;
        int off_len;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 6);
            rsp_ch.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            off_len = idle_gap();
            if (off_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.capacity      <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_RESERVE;
        req_ch.count         <= '0;
        req_ch.element_index <= '0;
        ring_span   = MAX_SLOTS;
        steady_feed = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The ring starts empty at full capacity; walk it to full, across the end and back.
        send_request(ACT_PEEK_IDX, 0, 0);
        send_request(ACT_RESERVE, 0, 0);
        send_request(ACT_CONSUME, 5, 0);
        send_request(ACT_PEEK_SPAN, 3, 0);
        send_request(ACT_COMMIT, 2047, 0);
        send_request(ACT_COMMIT, 1025, 0);
        send_request(ACT_COMMIT, 1000, 0);
        send_request(ACT_COMMIT, 100, 0);
        send_request(ACT_COMMIT, 24, 0);
        send_request(ACT_RESERVE, 0, 0);
        send_request(ACT_COMMIT, 0, 0);
        send_request(ACT_PEEK_SPAN, 2047, 0);
        send_request(ACT_PEEK_IDX, 0, 1023);
        send_request(ACT_CONSUME, 1000, 0);
        send_request(ACT_COMMIT, 500, 0);
        send_request(ACT_PEEK_SPAN, 600, 0);
        send_request(ACT_PEEK_IDX, 0, 1023);
        send_request(ACT_PEEK_IDX, 0, 100);
        send_request(ACT_CONSUME, 2047, 0);
        send_request(ACT_UNKNOWN, 2047, 1023);
        send_request(ACT_PEEK_IDX, 0, 0);
        req_ch.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(PHASE_CAPACITY[p]);
            steady_feed = (p % 3 == 1);
            random_burst(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
